// ----- rtl/core/rts_pkg.sv -----
// ----------------------------------------------------------------------------
// rts_pkg: per-tag rssi statistics package
// Widths, constants and beat layouts shared by the core and its channels.
// ----------------------------------------------------------------------------
package rts_pkg;

  localparam int NUM_TAGS    = 256;
  localparam int TAG_IDX_W   = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;

  localparam int TAG_W       = 8;
  localparam int MAG_W       = 7;
  localparam int DBM_W       = 8;
  localparam int EMA_W       = 16;
  localparam int CNT_W       = 32;
  localparam int ALPHA_W     = 9;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(256);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(26);

  // one received packet
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [MAG_W-1:0] rssi_magnitude;
    logic             crc_ok;
  } in_item_t;

  // statistics reported for one packet
  typedef struct packed {
    logic                    accepted;
    logic [TAG_W-1:0]        tag_out;
    logic                    first_time;
    logic [CNT_W-1:0]        tag_count;
    logic signed [DBM_W-1:0] min_dbm;
    logic signed [DBM_W-1:0] max_dbm;
    logic signed [EMA_W-1:0] ema_q8;
    logic [CNT_W-1:0]        total_good;
  } out_item_t;

  // one entry of the per-tag statistics memory
  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [DBM_W-1:0] min_dbm;
    logic signed [DBM_W-1:0] max_dbm;
    logic signed [EMA_W-1:0] ema;
  } stat_entry_t;

endpackage

// ----- rtl/core/rts_in_if.sv -----
// ----------------------------------------------------------------------------
// rts_in_if: packet event channel
// Valid/ready channel carrying one received packet per beat.
// ----------------------------------------------------------------------------
interface rts_in_if;
  import rts_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/core/rts_out_if.sv -----
// ----------------------------------------------------------------------------
// rts_out_if: statistics result channel
// Valid/ready channel carrying one statistics report per beat.
// ----------------------------------------------------------------------------
interface rts_out_if;
  import rts_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/core/per_tag_rssi_stats_core.sv -----
// ----------------------------------------------------------------------------
// per_tag_rssi_stats_core: per-tag rssi min / max / moving average tracker
// Keeps packet counts and signal statistics for every tag id and reports the
// updated statistics of the addressed tag for each received packet.
// ----------------------------------------------------------------------------
// A packet beat is taken every cycle while the result register is free or
// being drained. Its report passes through stage 1 on its way to the result
// register: the statistics memory is read on the accepting edge into stage
// 1, and the update is registered into the result register when the
// pipeline advances. Sustained rate is one beat per cycle; the only thing
// that slows it is back-pressure on the result channel. The statistics
// memory has one read port (address from the incoming beat) and one write
// port (update of the beat held in stage 1); a one-entry bypass covers
// back-to-back packets for the same tag. Seen flags live in flip-flops and
// clear at reset, so no clearing pass is needed after reset. Bad-CRC packets
// and tags at or above NUM_TAGS leave all state alone and report zeros with
// the current good-packet total. The smoothing weight is taken from
// cfg_wr_data on any cycle with cfg_wr_en high and must only change while
// the core is idle.
module per_tag_rssi_stats_core (
  input  logic                        clk,
  input  logic                        rst_n,
  rts_in_if.sink                      in_ch,
  rts_out_if.source                   out_ch,
  input  logic                        cfg_wr_en,
  input  logic [rts_pkg::ALPHA_W-1:0] cfg_wr_data
);
  import rts_pkg::*;

  // pipeline advance: result register empty or being taken
  logic advance;
  logic in_fire;

  // configuration
  logic [ALPHA_W-1:0] alpha_r;

  // statistics storage
  stat_entry_t         stat_mem [NUM_TAGS];
  logic [NUM_TAGS-1:0] seen_r;
  logic [CNT_W-1:0]    total_good_r;

  // stage 1: beat whose memory read is in flight
  logic                    s1_valid_r;
  logic [TAG_W-1:0]        s1_tag_r;
  logic signed [DBM_W-1:0] s1_x_r;
  logic                    s1_good_r;
  stat_entry_t             rd_entry_r;

  // last write, for same-tag back-to-back packets
  logic                 wr_valid_r;
  logic [TAG_IDX_W-1:0] wr_idx_r;
  stat_entry_t          wr_entry_r;

  // result register
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;

  // update datapath
  logic [TAG_IDX_W-1:0]    in_idx;
  logic [TAG_IDX_W-1:0]    s1_idx;
  logic                    in_good;
  logic signed [DBM_W-1:0] in_x;
  stat_entry_t             cur_entry;
  stat_entry_t             new_entry;
  logic                    seen;
  logic                    do_write;
  logic [ALPHA_W-1:0]      alpha_sat;
  logic signed [EMA_W-1:0] x_q8;
  logic signed [EMA_W:0]   ema_diff;
  logic signed [EMA_W+ALPHA_W+1:0] ema_prod;
  logic [CNT_W-1:0]        total_good_nxt;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;
  assign in_fire     = in_ch.valid && advance;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // incoming beat decode
  assign in_idx  = in_ch.data.tag[TAG_IDX_W-1:0];
  assign in_good = in_ch.data.crc_ok &&
                   ({1'b0, in_ch.data.tag} < (TAG_W+1)'(NUM_TAGS));
  assign in_x    = DBM_W'(0) - signed'({1'b0, in_ch.data.rssi_magnitude});

  assign s1_idx  = s1_tag_r[TAG_IDX_W-1:0];

  // stage 1 update
  always_comb begin
    // freshest copy of the entry: last write wins over the memory read
    if (wr_valid_r && (wr_idx_r == s1_idx)) begin
      cur_entry = wr_entry_r;
    end else begin
      cur_entry = rd_entry_r;
    end
    seen = seen_r[s1_idx];

    alpha_sat = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    x_q8      = {s1_x_r, 8'h00};
    ema_diff  = {x_q8[EMA_W-1], x_q8} - {cur_entry.ema[EMA_W-1], cur_entry.ema};
    // floor division by 256 is the arithmetic shift of the product
    ema_prod  = signed'({1'b0, alpha_sat}) * ema_diff;

    if (!seen) begin
      new_entry.count   = CNT_W'(1);
      new_entry.min_dbm = s1_x_r;
      new_entry.max_dbm = s1_x_r;
      new_entry.ema     = x_q8;
    end else begin
      new_entry.count   = cur_entry.count + CNT_W'(1);
      new_entry.min_dbm = (s1_x_r < cur_entry.min_dbm) ? s1_x_r : cur_entry.min_dbm;
      new_entry.max_dbm = (s1_x_r > cur_entry.max_dbm) ? s1_x_r : cur_entry.max_dbm;
      new_entry.ema     = cur_entry.ema + ema_prod[EMA_W+7:8];
    end

    do_write       = advance && s1_valid_r && s1_good_r;
    total_good_nxt = total_good_r + CNT_W'(1);

    if (s1_good_r) begin
      out_data_nxt.accepted   = 1'b1;
      out_data_nxt.tag_out    = s1_tag_r;
      out_data_nxt.first_time = !seen;
      out_data_nxt.tag_count  = new_entry.count;
      out_data_nxt.min_dbm    = new_entry.min_dbm;
      out_data_nxt.max_dbm    = new_entry.max_dbm;
      out_data_nxt.ema_q8     = new_entry.ema;
      out_data_nxt.total_good = total_good_nxt;
    end else begin
      out_data_nxt.accepted   = 1'b0;
      out_data_nxt.tag_out    = s1_tag_r;
      out_data_nxt.first_time = 1'b0;
      out_data_nxt.tag_count  = '0;
      out_data_nxt.min_dbm    = '0;
      out_data_nxt.max_dbm    = '0;
      out_data_nxt.ema_q8     = '0;
      out_data_nxt.total_good = total_good_r;
    end
  end

  // statistics memory: read on beat accept, write on stage 1 update
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_entry_r <= stat_mem[in_idx];
    end
    if (do_write) begin
      stat_mem[s1_idx] <= new_entry;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= ALPHA_RESET;
      seen_r       <= '0;
      total_good_r <= '0;
      s1_valid_r   <= 1'b0;
      wr_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        alpha_r <= cfg_wr_data;
      end
      if (advance) begin
        s1_valid_r  <= in_ch.valid;
        out_valid_r <= s1_valid_r;
      end
      if (do_write) begin
        seen_r[s1_idx] <= 1'b1;
        total_good_r   <= total_good_nxt;
        wr_valid_r     <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tag_r  <= in_ch.data.tag;
      s1_x_r    <= in_x;
      s1_good_r <= in_good;
    end
    if (do_write) begin
      wr_idx_r   <= s1_idx;
      wr_entry_r <= new_entry;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: per-tag rssi statistics core testbench
// Sends packet events through the valid/ready input channel, recomputes each
// tag's count, min, max and moving average in a local model, and compares
// every statistics beat field by field. Both sides idle at random. The
// smoothing weight is changed between phases while the core is drained.
// ----------------------------------------------------------------------------
module tb_top;
  import rts_pkg::*;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int HOLDOFF_AT   = 600;   // result count that starts the long stall
  localparam int HOLDOFF_LEN  = 150;
  localparam int RAND_PER_SET = 215;
  localparam int MAX_PRINTS   = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [ALPHA_W-1:0] cfg_wr_data = '0;

  rts_in_if  in_ch ();
  rts_out_if out_ch ();

  per_tag_rssi_stats_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // packets waiting to be sent and reports waiting to arrive
  in_item_t  pending_pkts[$];
  out_item_t pending_reports[$];

  // local copy of the per-tag statistics
  bit                tag_seen[NUM_TAGS];
  logic [CNT_W-1:0]  tag_hits[NUM_TAGS];
  int                tag_low[NUM_TAGS];
  int                tag_high[NUM_TAGS];
  int                tag_avg[NUM_TAGS];
  logic [CNT_W-1:0]  good_pkts;
  int                alpha_shadow;

  int  err_count = 0;
  int  pkts_queued = 0;
  int  results_seen = 0;
  bit  no_idle = 1'b0;
  int  tx_gap = 0;
  int  rx_wait = 0;
  bit  holdoff_done = 1'b0;
  int  quiet_cycles = 0;

  task automatic report_error(input string msg);
    if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // statistics update for one packet, returns the report it should produce
  function automatic out_item_t predict_report(in_item_t pkt);
    out_item_t r;
    int        x;
    int        a;
    int        step;
    int        t;
    r = '0;
    t = int'(pkt.tag);
    r.tag_out = pkt.tag;
    // bad crc or out-of-range tag: nothing moves, zeros plus current total
    if (!pkt.crc_ok || t >= NUM_TAGS) begin
      r.total_good = good_pkts;
      return r;
    end
    x = -int'(pkt.rssi_magnitude);
    good_pkts++;
    tag_hits[t]++;
    if (!tag_seen[t]) begin
      // first packet seeds min, max and average
      tag_seen[t]  = 1'b1;
      tag_low[t]   = x;
      tag_high[t]  = x;
      tag_avg[t]   = x * 256;
      r.first_time = 1'b1;
    end else begin
      // weight saturates at one
      a = (alpha_shadow > int'(ALPHA_ONE)) ? int'(ALPHA_ONE) : alpha_shadow;
      if (x < tag_low[t]) tag_low[t] = x;
      if (x > tag_high[t]) tag_high[t] = x;
      // arithmetic shift gives the floor of the quotient
      step = (a * (x * 256 - tag_avg[t])) >>> 8;
      tag_avg[t] += step;
    end
    r.accepted   = 1'b1;
    r.tag_count  = tag_hits[t];
    r.min_dbm    = tag_low[t][DBM_W-1:0];
    r.max_dbm    = tag_high[t][DBM_W-1:0];
    r.ema_q8     = tag_avg[t][EMA_W-1:0];
    r.total_good = good_pkts;
    return r;
  endfunction

  // driver: one packet per beat, random gap after each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pending_reports.push_back(predict_report(in_ch.data));
      end
      if (in_ch.valid && !in_ch.ready) begin
        // stalled, hold the beat
      end else if (tx_gap > 0) begin
        in_ch.valid <= 1'b0;
        tx_gap--;
      end else if (pending_pkts.size() > 0) begin
        in_ch.data  <= pending_pkts.pop_front();
        in_ch.valid <= 1'b1;
        tx_gap = no_idle ? 0 : $urandom_range(0, 12);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: checks each statistics beat against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_seen++;
        if (pending_reports.size() == 0) begin
          report_error($sformatf("beat for tag %0d with nothing expected", got.tag_out));
        end else begin
          want = pending_reports.pop_front();
          if (got.accepted !== want.accepted)
            report_error($sformatf("result %0d accepted %0b, expected %0b",
                                   results_seen, got.accepted, want.accepted));
          if (got.tag_out !== want.tag_out)
            report_error($sformatf("result %0d tag_out %0d, expected %0d",
                                   results_seen, got.tag_out, want.tag_out));
          if (got.first_time !== want.first_time)
            report_error($sformatf("result %0d first_time %0b, expected %0b",
                                   results_seen, got.first_time, want.first_time));
          if (got.tag_count !== want.tag_count)
            report_error($sformatf("result %0d tag_count %0d, expected %0d",
                                   results_seen, got.tag_count, want.tag_count));
          if (got.min_dbm !== want.min_dbm)
            report_error($sformatf("result %0d min_dbm %0d, expected %0d",
                                   results_seen, got.min_dbm, want.min_dbm));
          if (got.max_dbm !== want.max_dbm)
            report_error($sformatf("result %0d max_dbm %0d, expected %0d",
                                   results_seen, got.max_dbm, want.max_dbm));
          if (got.ema_q8 !== want.ema_q8)
            report_error($sformatf("result %0d ema_q8 %0d, expected %0d",
                                   results_seen, got.ema_q8, want.ema_q8));
          if (got.total_good !== want.total_good)
            report_error($sformatf("result %0d total_good %0d, expected %0d",
                                   results_seen, got.total_good, want.total_good));
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, 12);
        // one long stall so the core backs up and drops in_ch.ready
        if (!holdoff_done && results_seen == HOLDOFF_AT) begin
          rx_wait = HOLDOFF_LEN;
          holdoff_done = 1'b1;
        end
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ch.ready <= (rx_wait == 0);
    end
  end

  // watchdog: too long without a beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic queue_pkt(input int tag, input int mag, input bit ok);
    in_item_t p;
    p.tag            = tag[TAG_W-1:0];
    p.rssi_magnitude = mag[MAG_W-1:0];
    p.crc_ok         = ok;
    pending_pkts.push_back(p);
    pkts_queued++;
  endtask

  // wait until every queued packet has reported
  task automatic drain();
    while (results_seen != pkts_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_alpha(input int v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[ALPHA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    alpha_shadow = v & 'h1FF;
  endtask

  // mostly a small hot set of tags so averages evolve over many updates
  task automatic random_pkts(input int n);
    int hot_base;
    int kind;
    int tag;
    int mag;
    hot_base = $urandom_range(0, NUM_TAGS - 8);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) tag = hot_base + $urandom_range(0, 7);
      else tag = $urandom_range(0, 255);
      if ($urandom_range(0, 4) == 0) mag = $urandom_range(0, 1) ? 127 : 0;
      else mag = $urandom_range(0, 127);
      queue_pkt(tag, mag, kind >= 90 ? 1'b0 : 1'b1);
    end
  endtask

  initial begin
    int alpha_plan[6];
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    good_pkts    = '0;
    alpha_shadow = int'(ALPHA_RESET);
    foreach (tag_seen[i]) begin
      tag_seen[i] = 1'b0;
      tag_hits[i] = '0;
      tag_low[i]  = 0;
      tag_high[i] = 0;
      tag_avg[i]  = 0;
    end
    alpha_plan = '{0, 256, 511, 1, 128, 0};
    alpha_plan[5] = $urandom_range(0, 511);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, first packet, bad crc, back-to-back same tag
    queue_pkt(0, 0, 1'b1);
    queue_pkt(0, 127, 1'b1);
    queue_pkt(0, 64, 1'b1);
    queue_pkt(255, 127, 1'b1);
    queue_pkt(255, 0, 1'b1);
    queue_pkt(255, 127, 1'b0);
    queue_pkt(9, 5, 1'b0);      // bad crc on a tag never seen
    queue_pkt(9, 5, 1'b1);
    queue_pkt('hAA, 'h55, 1'b1);
    queue_pkt('h55, 'h2A, 1'b1);
    queue_pkt('hAA, 'h2A, 1'b1);
    queue_pkt('h55, 'h55, 1'b1);
    queue_pkt(3, 100, 1'b1);
    queue_pkt(3, 1, 1'b1);
    queue_pkt(3, 127, 1'b1);
    queue_pkt(3, 0, 1'b1);
    queue_pkt(0, 0, 1'b0);
    random_pkts(RAND_PER_SET);

    // weight changes only with the core drained
    for (int i = 0; i < 6; i++) begin
      drain();
      write_alpha(alpha_plan[i]);
      no_idle = (i == 1);
      random_pkts(RAND_PER_SET);
    end

    drain();
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0)
      report_error($sformatf("%0d reports never arrived", pending_reports.size()));
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rts_pkg.sv
rtl/core/rts_in_if.sv
rtl/core/rts_out_if.sv
rtl/core/per_tag_rssi_stats_core.sv
tb/sv/tb_top.sv
